/* hw/rtl/utf8_to_code_point_decoder_defines.svh */
// ----------------------------------------------------------------------------
// utf8 decoder assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_CODE_POINT_DECODER_DEFINES_SVH
`define UTF8_TO_CODE_POINT_DECODER_DEFINES_SVH

`ifndef SYNTH
`define UTF8D_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define UTF8D_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`else
`define UTF8D_ASSERT(lbl, clk, rstn, prop, msg)
`define UTF8D_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

/* hw/rtl/utf8d_pkg.sv */
// ----------------------------------------------------------------------------
// utf8 decoder package
// shared types and constants of the utf8 to code point decoder
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned CodePointW = 21;
  localparam int unsigned KindW      = 2;
  localparam int unsigned TdataOutW  = 24;
  localparam int unsigned FifoDepth  = 4;

  localparam logic [ByteW-1:0] AsciiMax   = 8'h7F;
  localparam logic [ByteW-1:0] LeadMin    = 8'hC2;
  localparam logic [ByteW-1:0] LeadMax    = 8'hF4;
  localparam logic [ByteW-1:0] Lead2Max   = 8'hDF;
  localparam logic [ByteW-1:0] Lead3Max   = 8'hEF;
  localparam logic [ByteW-1:0] LeadE0     = 8'hE0;
  localparam logic [ByteW-1:0] LeadED     = 8'hED;
  localparam logic [ByteW-1:0] LeadF0     = 8'hF0;
  localparam logic [ByteW-1:0] LeadF4     = 8'hF4;
  localparam logic [ByteW-1:0] ContMin    = 8'h80;
  localparam logic [ByteW-1:0] ContMax    = 8'hBF;
  localparam logic [ByteW-1:0] ContMinE0  = 8'hA0;
  localparam logic [ByteW-1:0] ContMaxED  = 8'h9F;
  localparam logic [ByteW-1:0] ContMinF0  = 8'h90;
  localparam logic [ByteW-1:0] ContMaxF4  = 8'h8F;

  typedef enum logic [KindW-1:0] {
    KIND_CODE_POINT = 2'd0,
    KIND_MALFORMED  = 2'd1,
    KIND_TRUNCATED  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [CodePointW-1:0] code_point;
    kind_e                 kind;
    logic                  last;
  } result_t;

  // up to two results per input byte, slot 0 filled first
  typedef struct packed {
    logic    valid0;
    logic    valid1;
    result_t res0;
    result_t res1;
  } step_out_t;

endpackage

/* hw/rtl/utf8d_core.sv */
// ----------------------------------------------------------------------------
// utf8 decoder core
// sequence state and per-byte validation, one byte per cycle while step_i is high
// ----------------------------------------------------------------------------
`include "utf8_to_code_point_decoder_defines.svh"

module utf8d_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              step_i,
  input  logic [utf8d_pkg::ByteW-1:0]       byte_i,
  input  logic                              eos_i,
  output utf8d_pkg::step_out_t              out_o
);

  logic                               in_seq_q, in_seq_d;
  logic [utf8d_pkg::ByteW-1:0]        lead_q, lead_d;
  logic [1:0]                         cnt_q, cnt_d;
  logic [utf8d_pkg::CodePointW-1:0]   pv_q, pv_d;

  logic                               lead_emit;
  utf8d_pkg::result_t                 lead_res;
  logic                               lead_start;
  logic [utf8d_pkg::CodePointW-1:0]   lead_pv;
  logic [utf8d_pkg::ByteW-1:0]        lo, hi;
  logic                               bad;
  logic [utf8d_pkg::CodePointW-1:0]   acc;
  logic [1:0]                         cnt_inc, need;
  logic                               done;
  utf8d_pkg::step_out_t               out;

  // lead byte decode
  always_comb begin
    lead_emit  = 1'b1;
    lead_start = 1'b0;
    lead_pv    = '0;
    lead_res   = '{code_point: '0, kind: utf8d_pkg::KIND_MALFORMED, last: 1'b0};
    if (byte_i <= utf8d_pkg::AsciiMax) begin
      lead_res.code_point = utf8d_pkg::CodePointW'(byte_i);
      lead_res.kind       = utf8d_pkg::KIND_CODE_POINT;
    end else if (byte_i < utf8d_pkg::LeadMin || byte_i > utf8d_pkg::LeadMax) begin
      lead_res.kind = utf8d_pkg::KIND_MALFORMED;
    end else if (eos_i) begin
      lead_res.kind = utf8d_pkg::KIND_TRUNCATED;
    end else begin
      lead_emit  = 1'b0;
      lead_start = 1'b1;
      if (byte_i <= utf8d_pkg::Lead2Max) begin
        lead_pv = utf8d_pkg::CodePointW'(byte_i[4:0]);
      end else if (byte_i <= utf8d_pkg::Lead3Max) begin
        lead_pv = utf8d_pkg::CodePointW'(byte_i[3:0]);
      end else begin
        lead_pv = utf8d_pkg::CodePointW'(byte_i[2:0]);
      end
    end
  end

  // continuation range and sequence length
  always_comb begin
    lo = utf8d_pkg::ContMin;
    hi = utf8d_pkg::ContMax;
    if (cnt_q == 2'd0) begin
      case (lead_q)
        utf8d_pkg::LeadE0: lo = utf8d_pkg::ContMinE0;
        utf8d_pkg::LeadED: hi = utf8d_pkg::ContMaxED;
        utf8d_pkg::LeadF0: lo = utf8d_pkg::ContMinF0;
        utf8d_pkg::LeadF4: hi = utf8d_pkg::ContMaxF4;
        default: ;
      endcase
    end
    if (lead_q <= utf8d_pkg::Lead2Max) begin
      need = 2'd1;
    end else if (lead_q <= utf8d_pkg::Lead3Max) begin
      need = 2'd2;
    end else begin
      need = 2'd3;
    end
  end

  assign bad     = in_seq_q && (byte_i < lo || byte_i > hi);
  assign acc     = {pv_q[utf8d_pkg::CodePointW-7:0], byte_i[5:0]};
  assign cnt_inc = cnt_q + 2'd1;
  assign done    = cnt_inc >= need;

  always_comb begin
    in_seq_d = in_seq_q;
    lead_d   = lead_q;
    cnt_d    = cnt_q;
    pv_d     = pv_q;
    out      = '0;
    if (!in_seq_q || bad) begin
      if (bad) begin
        out.valid0      = 1'b1;
        out.res0.kind   = utf8d_pkg::KIND_MALFORMED;
        out.valid1      = lead_emit;
        out.res1        = lead_res;
      end else begin
        out.valid0      = lead_emit;
        out.res0        = lead_res;
      end
      in_seq_d = lead_start;
      lead_d   = lead_start ? byte_i : '0;
      cnt_d    = '0;
      pv_d     = lead_pv;
    end else begin
      pv_d  = acc;
      cnt_d = cnt_inc;
      if (done || eos_i) begin
        out.valid0          = 1'b1;
        out.res0.code_point = done ? acc : '0;
        out.res0.kind       = done ? utf8d_pkg::KIND_CODE_POINT
                                   : utf8d_pkg::KIND_TRUNCATED;
        in_seq_d = 1'b0;
        lead_d   = '0;
        cnt_d    = '0;
        pv_d     = '0;
      end
    end
    if (eos_i) begin
      if (out.valid1) begin
        out.res1.last = 1'b1;
      end else begin
        out.res0.last = 1'b1;
      end
    end
  end

  assign out_o = out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_seq_q <= 1'b0;
      lead_q   <= '0;
      cnt_q    <= '0;
      pv_q     <= '0;
    end else if (step_i) begin
      in_seq_q <= in_seq_d;
      lead_q   <= lead_d;
      cnt_q    <= cnt_d;
      pv_q     <= pv_d;
    end
  end

  `UTF8D_ASSERT_IMP(a_lead_range, clk_i, rst_ni, in_seq_q,
    lead_q >= utf8d_pkg::LeadMin && lead_q <= utf8d_pkg::LeadMax,
    "open sequence with invalid lead")
  `UTF8D_ASSERT_IMP(a_cnt_below_need, clk_i, rst_ni, in_seq_q, cnt_q < need,
    "continuation count reached sequence length")
  `UTF8D_ASSERT_IMP(a_second_after_bad, clk_i, rst_ni, out.valid1,
    out.valid0 && out.res0.kind == utf8d_pkg::KIND_MALFORMED && !out.res0.last,
    "second result without malformed first")
  `UTF8D_ASSERT_IMP(a_err_zero_cp, clk_i, rst_ni,
    out.valid0 && out.res0.kind != utf8d_pkg::KIND_CODE_POINT,
    out.res0.code_point == '0, "error result carries a code point")

endmodule

/* hw/rtl/utf8d_fifo.sv */
// ----------------------------------------------------------------------------
// utf8 decoder result queue
// small register queue taking up to two results per cycle, one out
// ----------------------------------------------------------------------------
module utf8d_fifo #(
  parameter int unsigned Depth = utf8d_pkg::FifoDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  utf8d_pkg::step_out_t  data_i,
  output logic                  room_o,
  output logic                  valid_o,
  input  logic                  pop_i,
  output utf8d_pkg::result_t    data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  utf8d_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d, wr_ptr1, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               wr0, wr1, pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign wr0     = push_i && data_i.valid0;
  assign wr1     = push_i && data_i.valid1;
  assign pop     = pop_i && (cnt_q != '0);
  assign wr_ptr1 = ptr_inc(wr_ptr_q);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (wr1) begin
      wr_ptr_d = ptr_inc(wr_ptr1);
    end else if (wr0) begin
      wr_ptr_d = wr_ptr1;
    end
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + CntW'(wr0) + CntW'(wr1) - CntW'(pop);
  end

  assign room_o  = cnt_q <= CntW'(Depth - 2);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr0) begin
      mem_q[wr_ptr_q] <= data_i.res0;
    end
    if (wr1) begin
      mem_q[wr_ptr1] <= data_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

/* hw/rtl/utf8_to_code_point_decoder.sv */
// ----------------------------------------------------------------------------
// utf8 to code point decoder
// validating utf-8 decoder giving 21-bit code points and error markers
// ----------------------------------------------------------------------------
// channel  | dir | tdata                  | tuser    | tlast
// s_axis   | in  | [7:0] byte_in          | -        | end_of_string
// m_axis   | out | [20:0] code_point      | [1:0] kind | last_of_string
//
// one byte per cycle while the queue has room; each byte is decoded in the
// cycle it is taken and its results land in a register queue feeding m_axis
// a bad continuation yields up to two results, the malformed marker first
// s_axis_tready drops while the queue has room for fewer than two results
// reset clears sequence state and empties the queue; no clearing pass
// ----------------------------------------------------------------------------
module utf8_to_code_point_decoder #(
  parameter int unsigned FifoDepth = utf8d_pkg::FifoDepth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [utf8d_pkg::ByteW-1:0]        s_axis_tdata,  // [7:0] byte_in
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [utf8d_pkg::TdataOutW-1:0]    m_axis_tdata,  // [20:0] code_point
  output logic [utf8d_pkg::KindW-1:0]        m_axis_tuser,  // [1:0] kind
  output logic                               m_axis_tlast
);

  logic                  room, step;
  utf8d_pkg::step_out_t  step_out;
  utf8d_pkg::result_t    head;

  assign s_axis_tready = room;
  assign step          = s_axis_tvalid && room;

  utf8d_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (s_axis_tdata),
    .eos_i  (s_axis_tlast),
    .out_o  (step_out)
  );

  utf8d_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step),
    .data_i  (step_out),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .pop_i   (m_axis_tready),
    .data_o  (head)
  );

  assign m_axis_tdata = utf8d_pkg::TdataOutW'(head.code_point);
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule
